// ===== rtl/sss_pkg.sv =====
// ---------------------------------------------------------------------------
// sss_pkg: shared types and constants for the SQL statement splitter
// Scanner modes, token classes, keyword tables and the event format that
// travels from the scanner to the result stage.
// ---------------------------------------------------------------------------
package sss_pkg;

  localparam int OFFSET_BITS_DEFAULT = 32;
  localparam int RESULT_W            = 32;
  localparam int QUEUE_DEPTH         = 4;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_TOKEN,
    MODE_LINE,
    MODE_BLOCK
  } scan_mode_t;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_DASH,
    PEND_SLASH,
    PEND_STAR
  } pend_kind_t;

  typedef enum logic [1:0] {
    TOK_NONE,
    TOK_IDENT,
    TOK_NUMBER,
    TOK_STRING
  } tok_class_t;

  typedef enum logic {
    KIND_STATEMENT = 1'b0,
    KIND_DONE      = 1'b1
  } result_kind_t;

  localparam logic [6:0] CH_NL    = 7'h0a;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_DQ    = 7'h22;
  localparam logic [6:0] CH_SQ    = 7'h27;
  localparam logic [6:0] CH_STAR  = 7'h2a;
  localparam logic [6:0] CH_DASH  = 7'h2d;
  localparam logic [6:0] CH_SLASH = 7'h2f;
  localparam logic [6:0] CH_SEMI  = 7'h3b;

  // One scanned byte's worth of results: an optional statement and an
  // optional end-of-script marker, in that order.
  typedef struct packed {
    logic                has_stmt;
    logic [RESULT_W-1:0] start;
    logic [RESULT_W-1:0] len;
    logic                semi;
    logic                has_done;
  } sss_event_t;

  function automatic logic [6:0] kw_begin_char(input logic [2:0] p);
    logic [6:0] c;
    unique case (p)
      3'd0:    c = 7'h62;  // b
      3'd1:    c = 7'h65;  // e
      3'd2:    c = 7'h67;  // g
      3'd3:    c = 7'h69;  // i
      3'd4:    c = 7'h6e;  // n
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] kw_end_char(input logic [2:0] p);
    logic [6:0] c;
    unique case (p)
      3'd0:    c = 7'h65;  // e
      3'd1:    c = 7'h6e;  // n
      3'd2:    c = 7'h64;  // d
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/sss_stream_if.sv =====
// ---------------------------------------------------------------------------
// sss_in_if / sss_out_if: valid/ready channels of the statement splitter
// Input carries script bytes; output carries statement and done results.
// ---------------------------------------------------------------------------
interface sss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] script_byte;
  logic       last_byte;

  modport source (output valid, output script_byte, output last_byte, input ready);
  modport sink   (input valid, input script_byte, input last_byte, output ready);
endinterface

interface sss_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] start_offset;
  logic [31:0] stmt_length;
  logic        ended_by_semicolon;
  logic        last_result;

  modport source (output valid, output result_kind, output start_offset,
                  output stmt_length, output ended_by_semicolon,
                  output last_result, input ready);
  modport sink   (input valid, input result_kind, input start_offset,
                  input stmt_length, input ended_by_semicolon,
                  input last_result, output ready);
endinterface

// ===== rtl/sss_front.sv =====
// ---------------------------------------------------------------------------
// sss_front: byte scanner
// Classifies each byte, tracks comments, strings, tokens and begin/end
// blocks, and pushes one event per byte that yields results.
// ---------------------------------------------------------------------------
module sss_front #(
  parameter int OFFSET_BITS = sss_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  sss_in_if.sink             script,
  input  logic               q_full,
  output logic               q_push,
  output sss_pkg::sss_event_t q_data
);
  import sss_pkg::*;

  scan_mode_t             mode, mode_next;
  pend_kind_t             pend, pend_next;
  tok_class_t             tok, tok_next;
  logic                   dq, dq_next;
  logic [2:0]             kwp, kwp_next;
  logic [1:0]             kwc, kwc_next;
  logic                   in_blk, in_blk_next;
  logic                   st_open, st_open_next;
  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [OFFSET_BITS-1:0] st_pos, st_pos_next;

  logic                   accept;
  logic [6:0]             m, l;
  logic                   do_fresh;
  logic                   is_space, is_digit, is_alpha;
  logic [6:0]             follow;
  scan_mode_t             into;
  sss_event_t             ev;

  assign script.ready = !q_full;
  assign accept       = script.valid && !q_full;
  assign m            = script.script_byte[6:0];
  assign l            = (m >= 7'h41 && m <= 7'h5a) ? m + 7'd32 : m;
  assign is_space     = (m >= 7'd9 && m <= 7'd13) || m == CH_SPACE;
  assign is_digit     = m >= 7'h30 && m <= 7'h39;
  assign is_alpha     = (m >= 7'h41 && m <= 7'h5a) || (m >= 7'h61 && m <= 7'h7a) ||
                        m == 7'h5f;

  always_comb begin
    mode_next    = mode;
    pend_next    = pend;
    tok_next     = tok;
    dq_next      = dq;
    kwp_next     = kwp;
    kwc_next     = kwc;
    in_blk_next  = in_blk;
    st_open_next = st_open;
    st_pos_next  = st_pos;
    pos_next     = pos + 1'b1;
    do_fresh     = 1'b0;
    follow       = (pend == PEND_DASH) ? CH_DASH : CH_STAR;
    into         = (pend == PEND_DASH) ? MODE_LINE : MODE_BLOCK;
    ev           = '0;

    unique case (mode)
      MODE_NORMAL: begin
        pend_next = PEND_NONE;
        if (pend == PEND_DASH || pend == PEND_SLASH) begin
          if (m == follow) begin
            mode_next = into;
          end else begin
            // lone '-' or '/' becomes a one-byte token at the previous offset
            if (!st_open_next) begin
              st_open_next = 1'b1;
              st_pos_next  = pos - 1'b1;
            end
            do_fresh = 1'b1;
          end
        end else begin
          do_fresh = 1'b1;
        end
      end
      MODE_TOKEN: begin
        unique case (tok)
          TOK_IDENT: begin
            if (is_alpha || is_digit) begin
              if (kwp >= 3'd5 || l != kw_begin_char(kwp)) kwc_next[0] = 1'b0;
              if (kwp >= 3'd3 || l != kw_end_char(kwp))   kwc_next[1] = 1'b0;
              if (kwp < 3'd7) kwp_next = kwp + 3'd1;
            end else begin
              if (kwc[0] && kwp == 3'd5)      in_blk_next = 1'b1;
              else if (kwc[1] && kwp == 3'd3) in_blk_next = 1'b0;
              do_fresh = 1'b1;
            end
          end
          TOK_NUMBER: begin
            if (!is_digit) do_fresh = 1'b1;
          end
          TOK_STRING: begin
            if (m == (dq ? CH_DQ : CH_SQ)) begin
              mode_next = MODE_NORMAL;
              tok_next  = TOK_NONE;
            end
          end
          TOK_NONE: do_fresh = 1'b1;
        endcase
      end
      MODE_LINE: begin
        if (m == CH_NL) mode_next = MODE_NORMAL;
      end
      MODE_BLOCK: begin
        if (pend == PEND_STAR && m == CH_SLASH) begin
          mode_next = MODE_NORMAL;
          pend_next = PEND_NONE;
        end else begin
          pend_next = (m == CH_STAR) ? PEND_STAR : PEND_NONE;
        end
      end
    endcase

    // byte met between tokens
    if (do_fresh) begin
      mode_next = MODE_NORMAL;
      tok_next  = TOK_NONE;
      if (is_space) begin
        // skipped
      end else if (m == CH_DASH) begin
        pend_next = PEND_DASH;
      end else if (m == CH_SLASH) begin
        pend_next = PEND_SLASH;
      end else begin
        if (!st_open_next) begin
          st_open_next = 1'b1;
          st_pos_next  = pos;
        end
        if (is_alpha) begin
          mode_next = MODE_TOKEN;
          tok_next  = TOK_IDENT;
          kwc_next  = {l == kw_end_char(3'd0), l == kw_begin_char(3'd0)};
          kwp_next  = 3'd1;
        end else if (is_digit) begin
          mode_next = MODE_TOKEN;
          tok_next  = TOK_NUMBER;
        end else if (m == CH_DQ || m == CH_SQ) begin
          mode_next = MODE_TOKEN;
          tok_next  = TOK_STRING;
          dq_next   = (m == CH_DQ);
        end else if (m == CH_SEMI && !in_blk_next) begin
          ev.has_stmt  = 1'b1;
          ev.start     = RESULT_W'(st_pos_next);
          ev.len       = RESULT_W'(pos + 1'b1 - st_pos_next);
          ev.semi      = 1'b1;
          st_open_next = 1'b0;
        end
      end
    end

    // end of script: flush pending token, open statement, then done
    if (script.last_byte) begin
      if (mode_next == MODE_NORMAL &&
          (pend_next == PEND_DASH || pend_next == PEND_SLASH) && !st_open_next) begin
        st_open_next = 1'b1;
        st_pos_next  = pos;
      end
      if (st_open_next) begin
        ev.has_stmt = 1'b1;
        ev.start    = RESULT_W'(st_pos_next);
        ev.len      = RESULT_W'(pos + 1'b1 - st_pos_next);
        ev.semi     = 1'b0;
      end
      ev.has_done  = 1'b1;
      mode_next    = MODE_NORMAL;
      pend_next    = PEND_NONE;
      tok_next     = TOK_NONE;
      dq_next      = 1'b0;
      kwp_next     = 3'd0;
      kwc_next     = 2'b11;
      in_blk_next  = 1'b0;
      st_open_next = 1'b0;
      st_pos_next  = '0;
      pos_next     = '0;
    end
  end

  assign q_push = accept && (ev.has_stmt || ev.has_done);
  assign q_data = ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_NORMAL;
      pend    <= PEND_NONE;
      tok     <= TOK_NONE;
      dq      <= 1'b0;
      kwp     <= 3'd0;
      kwc     <= 2'b11;
      in_blk  <= 1'b0;
      st_open <= 1'b0;
      pos     <= '0;
      st_pos  <= '0;
    end else if (accept) begin
      mode    <= mode_next;
      pend    <= pend_next;
      tok     <= tok_next;
      dq      <= dq_next;
      kwp     <= kwp_next;
      kwc     <= kwc_next;
      in_blk  <= in_blk_next;
      st_open <= st_open_next;
      pos     <= pos_next;
      st_pos  <= st_pos_next;
    end
  end

endmodule

// ===== rtl/sss_queue.sv =====
// ---------------------------------------------------------------------------
// sss_queue: event queue between scanner and result stage
// Small register FIFO; full and empty come straight from a count register.
// ---------------------------------------------------------------------------
module sss_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sss_pkg::sss_event_t push_data,
  output logic                full,
  input  logic                pop,
  output sss_pkg::sss_event_t pop_data,
  output logic                not_empty
);
  import sss_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sss_event_t       mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full      = count == CNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/sss_back.sv =====
// ---------------------------------------------------------------------------
// sss_back: result stage
// Holds one event in an output register and emits its statement result,
// then its done result, one transfer each.
// ---------------------------------------------------------------------------
module sss_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  sss_pkg::sss_event_t q_data,
  output logic                q_pop,
  sss_out_if.source           result
);
  import sss_pkg::*;

  sss_event_t cur;
  logic       stmt_pend, done_pend;
  logic       busy, xfer, drained;

  assign busy    = stmt_pend || done_pend;
  assign xfer    = busy && result.ready;
  assign drained = !busy || (xfer && !(stmt_pend && done_pend));
  assign q_pop   = q_valid && drained;

  assign result.valid              = busy;
  assign result.result_kind        = stmt_pend ? KIND_STATEMENT : KIND_DONE;
  assign result.start_offset       = stmt_pend ? cur.start : '0;
  assign result.stmt_length        = stmt_pend ? cur.len : '0;
  assign result.ended_by_semicolon = stmt_pend && cur.semi;
  assign result.last_result        = !stmt_pend && done_pend;

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stmt_pend <= 1'b0;
      done_pend <= 1'b0;
    end else if (q_pop) begin
      stmt_pend <= q_data.has_stmt;
      done_pend <= q_data.has_done;
    end else if (xfer) begin
      if (stmt_pend) stmt_pend <= 1'b0;
      else           done_pend <= 1'b0;
    end
  end

endmodule

// ===== rtl/sql_statement_splitter_unit.sv =====
// ---------------------------------------------------------------------------
// sql_statement_splitter_unit: SQL script statement splitter
// Splits a byte stream into statements at ';' outside begin/end blocks,
// skipping whitespace, comments and quoted strings between tokens.
// ---------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  script   in   valid/ready    script_byte[7:0], last_byte
//  result   out  valid/ready    result_kind, start_offset[31:0],
//                               stmt_length[31:0], ended_by_semicolon,
//                               last_result
//
//  One byte per cycle: the scanner updates its state in the cycle of the
//  transfer. A byte yields zero, one or two results; the output register
//  sends one per cycle while result.ready is high, so a final byte that
//  closes a statement needs two transfers, absorbed by the event queue.
//  rst (synchronous) returns the scanner to offset 0 and empties the queue.
//  script.ready drops only while the event queue is full; the result side
//  may stall freely without losing results.
//
module sql_statement_splitter_unit #(
  parameter int OFFSET_BITS = sss_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  sss_in_if.sink    script,
  sss_out_if.source result
);
  import sss_pkg::*;

  // scanner -> queue
  sss_event_t push_data;
  logic       push;
  logic       full;

  // queue -> result stage
  sss_event_t pop_data;
  logic       pop;
  logic       not_empty;

  // Front: one byte per transfer, emits an event when a statement closes
  // or the script ends.
  sss_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .script (script),
    .q_full (full),
    .q_push (push),
    .q_data (push_data)
  );

  // Queue decouples scanner stalls from result-side stalls.
  sss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  // Back: expands each event into its statement and done results.
  sss_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (not_empty),
    .q_data  (pop_data),
    .q_pop   (pop),
    .result  (result)
  );

endmodule

// ===== bench/sql_statement_splitter_unit_checker.sv =====
// ----------------------------------------------------------------------------
// Statement splitter checker
// Watches both channels. It rescans every accepted script byte with its own
// scanner and queues the statements and done markers that the byte must
// produce, then matches each accepted result against the oldest one queued.
// ----------------------------------------------------------------------------
module sql_statement_splitter_unit_checker (
  input  logic        clk,
  input  logic        rst,
  sss_in_if           script,
  sss_out_if          result,
  output int unsigned fail_count,
  output int unsigned outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import sss_pkg::*;

  localparam logic [39:0] KW_BEGIN = "begin";
  localparam logic [23:0] KW_END   = "end";

  typedef struct packed {
    result_kind_t kind;
    logic [31:0]  start;
    logic [31:0]  len;
    logic         semi;
    logic         last;
  } split_result_t;

  split_result_t split_q[$];
  int unsigned   mismatches;

  // scanner copy
  scan_mode_t  mode;
  pend_kind_t  pend;
  tok_class_t  tok;
  logic        dq_quote;
  logic [2:0]  kw_len;
  logic [1:0]  kw_live;    // bit 0: "begin" still possible, bit 1: "end"
  logic        in_block;
  logic        stmt_open;
  logic [31:0] byte_pos;
  logic [31:0] stmt_start;

  function automatic logic is_blank(input logic [6:0] c);
    return (c >= 7'd9 && c <= 7'd13) || c == CH_SPACE;
  endfunction

  function automatic logic is_numeral(input logic [6:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic ident_start(input logic [6:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  task automatic clear_scanner();
    mode       = MODE_NORMAL;
    pend       = PEND_NONE;
    tok        = TOK_NONE;
    dq_quote   = 1'b0;
    kw_len     = '0;
    kw_live    = 2'b11;
    in_block   = 1'b0;
    stmt_open  = 1'b0;
    byte_pos   = '0;
    stmt_start = '0;
  endtask

  task automatic push_result(input result_kind_t kind, input logic [31:0] start,
                             input logic [31:0] len, input logic semi);
    split_q.push_back('{kind, start, len, semi, kind == KIND_DONE});
  endtask

  task automatic open_statement(input logic [31:0] at);
    if (!stmt_open) begin
      stmt_open  = 1'b1;
      stmt_start = at;
    end
  endtask

  task automatic feed_letter(input logic [6:0] c);
    logic [6:0] lc;
    int         k;
    lc = (c >= "A" && c <= "Z") ? c + 7'd32 : c;
    k  = kw_len;
    if (k >= 5) kw_live[0] = 1'b0;
    else if (lc != KW_BEGIN[8*(4-k) +: 7]) kw_live[0] = 1'b0;
    if (k >= 3) kw_live[1] = 1'b0;
    else if (lc != KW_END[8*(2-k) +: 7]) kw_live[1] = 1'b0;
    if (kw_len != 3'd7) kw_len = kw_len + 3'd1;
  endtask

  task automatic close_ident();
    if (kw_live[0] && kw_len == 3'd5) in_block = 1'b1;
    else if (kw_live[1] && kw_len == 3'd3) in_block = 1'b0;
  endtask

  // byte seen between tokens with nothing pending
  task automatic begin_token(input logic [6:0] c, input logic [31:0] at);
    mode = MODE_NORMAL;
    tok  = TOK_NONE;
    if (c == CH_DASH) pend = PEND_DASH;
    else if (c == CH_SLASH) pend = PEND_SLASH;
    else if (!is_blank(c)) begin
      open_statement(at);
      if (ident_start(c)) begin
        mode    = MODE_TOKEN;
        tok     = TOK_IDENT;
        kw_len  = '0;
        kw_live = 2'b11;
        feed_letter(c);
      end else if (is_numeral(c)) begin
        mode = MODE_TOKEN;
        tok  = TOK_NUMBER;
      end else if (c == CH_DQ || c == CH_SQ) begin
        mode     = MODE_TOKEN;
        tok      = TOK_STRING;
        dq_quote = (c == CH_DQ);
      end else if (c == CH_SEMI && !in_block) begin
        push_result(KIND_STATEMENT, stmt_start, at + 32'd1 - stmt_start, 1'b1);
        stmt_open = 1'b0;
      end
    end
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic lst);
    logic [6:0]  c;
    logic [31:0] at;
    logic        was_dash;
    c  = b[6:0];
    at = byte_pos;
    case (mode)
      MODE_NORMAL: begin
        if (pend == PEND_DASH || pend == PEND_SLASH) begin
          was_dash = (pend == PEND_DASH);
          pend     = PEND_NONE;
          if (was_dash ? c == CH_DASH : c == CH_STAR) begin
            mode = was_dash ? MODE_LINE : MODE_BLOCK;
          end else begin
            open_statement(at - 32'd1);
            begin_token(c, at);
          end
        end else begin
          pend = PEND_NONE;
          begin_token(c, at);
        end
      end
      MODE_TOKEN: begin
        case (tok)
          TOK_IDENT: begin
            if (ident_start(c) || is_numeral(c)) feed_letter(c);
            else begin
              close_ident();
              begin_token(c, at);
            end
          end
          TOK_NUMBER: if (!is_numeral(c)) begin_token(c, at);
          TOK_STRING: begin
            if (c == (dq_quote ? CH_DQ : CH_SQ)) begin
              mode = MODE_NORMAL;
              tok  = TOK_NONE;
            end
          end
          default: begin_token(c, at);
        endcase
      end
      MODE_LINE: if (c == CH_NL) mode = MODE_NORMAL;
      default: begin
        if (pend == PEND_STAR && c == CH_SLASH) begin
          mode = MODE_NORMAL;
          pend = PEND_NONE;
        end else begin
          pend = (c == CH_STAR) ? PEND_STAR : PEND_NONE;
        end
      end
    endcase
    byte_pos = at + 32'd1;
    if (lst) begin
      if (mode == MODE_NORMAL && (pend == PEND_DASH || pend == PEND_SLASH))
        open_statement(at);
      if (stmt_open)
        push_result(KIND_STATEMENT, stmt_start, at + 32'd1 - stmt_start, 1'b0);
      push_result(KIND_DONE, '0, '0, 1'b0);
      clear_scanner();
    end
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
  endtask

  initial begin
    clear_scanner();
    mismatches = 0;
  end

  // results are compared before the byte of the same edge is scanned: a byte
  // can never produce a result in the cycle of its own transfer
  always @(posedge clk) begin : watch
    split_result_t want;
    if (rst) begin
      clear_scanner();
      split_q.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (split_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, got kind=%0d start=%0d len=%0d",
                   $time, result.result_kind, result.start_offset, result.stmt_length);
        end else begin
          want = split_q.pop_front();
          if (result.result_kind !== want.kind)
            note_mismatch("result_kind", want.kind, result.result_kind);
          if (result.start_offset !== want.start)
            note_mismatch("start_offset", want.start, result.start_offset);
          if (result.stmt_length !== want.len)
            note_mismatch("stmt_length", want.len, result.stmt_length);
          if (result.ended_by_semicolon !== want.semi)
            note_mismatch("ended_by_semicolon", want.semi, result.ended_by_semicolon);
          if (result.last_result !== want.last)
            note_mismatch("last_result", want.last, result.last_result);
        end
      end
      if (script.valid && script.ready) scan_byte(script.script_byte, script.last_byte);
    end
    fail_count  <= mismatches;
    outstanding <= split_q.size();
  end

endmodule

// ===== bench/sql_statement_splitter_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Statement splitter testbench
// Feeds short SQL scripts byte by byte: a few hand-written corner scripts,
// then random scripts built from identifiers, keywords, numbers, strings,
// comments, whitespace, semicolons and noise, under changing idle and stall
// patterns. The checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module sql_statement_splitter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned PHASE_BYTES = 200;   // random bytes per idle phase
  localparam int unsigned HOLD_CYCLES = 150;   // long result-side hold-off
  localparam int unsigned TAIL_CYCLES = 20;

  logic clk;
  logic rst;

  sss_in_if  script_ch ();
  sss_out_if result_ch ();

  int unsigned fail_count;
  int unsigned outstanding;

  // knobs shared by the sender and receiver processes
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_req;
  int unsigned bytes_sent;
  int unsigned cycle_count;

  // script under construction, sent as one burst of transfers
  logic [7:0] script_q[$];

  sql_statement_splitter_unit dut (
    .clk    (clk),
    .rst    (rst),
    .script (script_ch),
    .result (result_ch)
  );

  sql_statement_splitter_unit_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .script      (script_ch),
    .result      (result_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Script building
  // --------------------------------------------------------------------------
  function automatic logic [7:0] pick(input string chars);
    return chars[$urandom_range(chars.len() - 1)];
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) script_q.push_back(s[i]);
  endtask

  // keyword letters in random case, since matching ignores case
  task automatic add_keyword(input string s);
    logic [7:0] ch;
    for (int i = 0; i < s.len(); i++) begin
      ch = s[i];
      script_q.push_back($urandom_range(1) ? ch - 8'd32 : ch);
    end
  endtask

  task automatic add_fragment();
    logic [7:0] quote;
    case ($urandom_range(14))
      0, 1: begin
        script_q.push_back(pick("abcxyzABQZ_"));
        repeat ($urandom_range(5)) script_q.push_back(pick("aeinbdgXY_09"));
      end
      2: add_keyword("begin");
      3: add_keyword("end");
      4: begin
        // near misses must not toggle the begin/end block
        case ($urandom_range(3))
          0:       add_keyword("begi");
          1:       add_keyword("beginx");
          2:       add_keyword("endd");
          default: add_keyword("en");
        endcase
      end
      5: repeat ($urandom_range(1, 4)) script_q.push_back(pick("0123456789"));
      6: begin
        quote = $urandom_range(1) ? 8'h22 : 8'h27;
        script_q.push_back(quote);
        repeat ($urandom_range(5)) script_q.push_back(pick("ab ;'\"-*/"));
        if ($urandom_range(9) != 0) script_q.push_back(quote);
      end
      7: begin
        add_text("--");
        repeat ($urandom_range(4)) script_q.push_back(pick("x ;'*"));
        if ($urandom_range(4) != 0) add_text("\n");
      end
      8: begin
        add_text("/*");
        repeat ($urandom_range(5)) script_q.push_back(pick("*/;a "));
        if ($urandom_range(6) != 0) add_text("*/");
      end
      9, 10: repeat ($urandom_range(1, 3)) script_q.push_back(pick(" \t\n\r\013\014"));
      11, 12: add_text(";");
      13: script_q.push_back(pick("-/*(),=."));
      default: script_q.push_back(8'($urandom_range(255)));
    endcase
  endtask

  // Mostly well-formed scripts; some pure noise, some cut short so strings
  // and comments run into the end of input. Bit 7 is set now and then since
  // the block classes bytes on their low seven bits only.
  task automatic build_random_script();
    int n;
    script_q.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 8)) script_q.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 10)) add_fragment();
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(1, script_q.size());
        while (script_q.size() > n) void'(script_q.pop_back());
      end
    end
    foreach (script_q[i]) if ($urandom_range(19) == 0) script_q[i][7] = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Script channel driver
  // --------------------------------------------------------------------------
  // Valid stays up between back-to-back transfers; an idle gap first lowers it
  // until a random draw ends the gap.
  task automatic put_byte(input logic [7:0] b, input logic lst);
    if ($urandom_range(99) < send_idle_pct) begin
      script_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    script_ch.valid       <= 1'b1;
    script_ch.script_byte <= b;
    script_ch.last_byte   <= lst;
    do @(posedge clk); while (!script_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_script();
    foreach (script_q[i]) put_byte(script_q[i], i == script_q.size() - 1);
  endtask

  task automatic send_text(input string s);
    script_q.delete();
    add_text(s);
    send_script();
  endtask

  // --------------------------------------------------------------------------
  // Result channel: random stalls, plus one long hold-off on request so the
  // event queue fills and the block has to drop script.ready.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // hard stop if the block hangs or a result never shows up
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sql_statement_splitter_unit_tb: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and verdict
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned goal;
    send_idle_pct          = 0;
    recv_stall_pct         = 0;
    hold_req               = 1'b0;
    bytes_sent             = 0;
    rst                   <= 1'b1;
    script_ch.valid       <= 1'b0;
    script_ch.script_byte <= '0;
    script_ch.last_byte   <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed scripts, no idling.
    // "/*/" must not close the comment; the trailing lone dash becomes a
    // token at end of input.
    send_text("x/*/;*/-");
    // upper-case begin hides the first ';' until end
    send_text("BEGIN;end;");
    // NUL, DEL, 0xff (DEL once masked), then a string never closed
    script_q = '{8'h00, 8'h7f, 8'hff, 8'h22};
    send_script();
    // line comment skipped; statement starts at the number
    send_text("--\n9;");
    // single pending slash at end of input
    send_text("/");
    // single ';' that closes an empty statement right at the last byte
    send_text(";");

    // Random scripts under four idle/stall mixes.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      goal = bytes_sent + PHASE_BYTES;
      while (bytes_sent < goal) begin
        build_random_script();
        send_script();
      end
    end

    // Back pressure: results held off while a dense run of statements
    // keeps arriving at full rate.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    script_q.delete();
    repeat (24) begin
      if ($urandom_range(1)) add_text("x");
      add_text(";");
    end
    send_script();
    script_ch.valid <= 1'b0;

    // Drain: the checker's counts are registered, so let them update before polling.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("sql_statement_splitter_unit_tb: PASS");
    end else begin
      $display("sql_statement_splitter_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
